[sv/chs_pkg.sv]
// chs_pkg: shared types and constants for the chained hash set core
// no dependencies
`timescale 1ns / 1ps

package chs_pkg;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;
  localparam int TOTAL_W = 11;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  typedef enum logic [1:0] {
    MOP_XSH,
    MOP_MUL1,
    MOP_MUL2
  } mix_op_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mix_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_READ,
    ST_READ_WAIT,
    ST_CMP,
    ST_ALLOC,
    ST_ALLOC_WAIT,
    ST_UPDATE,
    ST_OUT
  } state_t;

endpackage

[sv/chs_if.sv]
// chs_if: valid/ready request and response channels, each payload field a separate signal
// depends on nothing
`timescale 1ns / 1ps

interface chs_req_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [63:0] key;
  modport source (output valid, action, key, input ready);
  modport sink (input valid, action, key, output ready);
endinterface

interface chs_rsp_if (input logic clk);
  logic valid;
  logic ready;
  logic success;
  logic pool_full;
  logic [10:0] element_total;
  modport source (output valid, success, pool_full, element_total, input ready);
  modport sink (input valid, success, pool_full, element_total, output ready);
endinterface

[sv/chs_mix.sv]
// chs_mix: murmur3 64-bit finalizer on one shared unit
// 32x32 partial product multiplier reused for each partial product; uses chs_pkg
`timescale 1ns / 1ps

module chs_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output chs_pkg::mix_ctl_t ctl,
  output logic [63:0] dout
);

  // sequence: xsh mul1 xsh mul2 xsh; each multiply is three partial products
  logic [63:0] acc;
  logic [2:0] step;
  logic [1:0] part;
  logic busy;
  logic done;
  logic [63:0] prod_sum;
  chs_pkg::mix_op_t op;
  logic [63:0] cst;
  logic [31:0] pa;
  logic [31:0] pb;
  logic [63:0] pp;
  logic [63:0] mul_base;

  always_comb begin
    case (step)
      3'd1: op = chs_pkg::MOP_MUL1;
      3'd3: op = chs_pkg::MOP_MUL2;
      default: op = chs_pkg::MOP_XSH;
    endcase
    cst = (op == chs_pkg::MOP_MUL2) ? chs_pkg::MIX_C2 : chs_pkg::MIX_C1;
    case (part)
      2'd0: begin pa = acc[31:0]; pb = cst[31:0]; end
      2'd1: begin pa = acc[63:32]; pb = cst[31:0]; end
      default: begin pa = acc[31:0]; pb = cst[63:32]; end
    endcase
    pp = {32'd0, pa} * {32'd0, pb};
    mul_base = (part == 2'd0) ? 64'd0 : prod_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      part <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
        part <= '0;
        acc <= din;
      end else if (busy) begin
        if (op == chs_pkg::MOP_XSH) begin
          acc <= acc ^ (acc >> chs_pkg::MIX_SHIFT);
          if (step == 3'd4) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          step <= step + 3'd1;
        end else begin
          case (part)
            2'd0: prod_sum <= pp;
            default: prod_sum <= mul_base + {pp[31:0], 32'd0};
          endcase
          if (part == 2'd2) begin
            part <= '0;
            acc <= mul_base + {pp[31:0], 32'd0};
            step <= step + 3'd1;
          end else begin
            part <= part + 2'd1;
          end
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy;
  assign ctl.done = done;
  assign dout = acc;

endmodule

[sv/chained_hash_set_core.sv]
// chained_hash_set_core: hashed set of 64-bit keys with chained buckets
// Usage:
//   req channel takes one item (action, key); rsp channel returns one item
//   (success, pool_full, element_total) for every request.
//   action 0 inserts, 1 finds, 2 removes; action 3 changes nothing.
// Flow: the hash runs on the shared 32x32 multiplier (two 64-bit multiplies
//   of three partial products, three shift-xor steps, start and done); each
//   visited node passes READ, READ_WAIT and CMP, set by the single read port
//   of the node memories with registered read data, and an insert that reuses
//   a freed node adds ALLOC and ALLOC_WAIT. One item is in flight at a time;
//   req.ready is low meanwhile and returns once out_valid has cleared and the
//   state has gone from OUT back to IDLE.
// Reset: clears the bucket head valid bits, free list head, fresh pointer
//   and key count; no clearing pass is needed.
// Stall: the result is held in the output register until rsp.ready; the
//   next request is taken only after the result has been delivered.
// Chains walk at most POOL_NODES steps.
`timescale 1ns / 1ps

module chained_hash_set_core #(
  parameter int BUCKET_COUNT = 256,
  parameter int POOL_NODES = 1024
) (
  input logic clk,
  input logic rst,
  chs_req_if.sink req,
  chs_rsp_if.source rsp
);

  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int BW = (BUCKET_COUNT > 2) ? $clog2(BUCKET_COUNT) : 1;
  localparam int AW = (POOL_NODES > 2) ? $clog2(POOL_NODES) : 1;
  localparam int TW = chs_pkg::TOTAL_W;
  localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);
  localparam logic [BW-1:0] BMASK = BW'(BUCKET_COUNT - 1);

  chs_pkg::state_t state, state_next;

  logic [NW-1:0] heads [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] head_ok;
  logic [63:0] keys [POOL_NODES];
  logic [NW-1:0] links [POOL_NODES];

  logic [1:0] action;
  logic [63:0] key;
  logic [BW-1:0] bucket;
  logic [NW-1:0] cur, prev, node;
  logic [NW-1:0] free_head, fresh, count;
  logic [NW:0] steps;
  logic [63:0] rd_key;
  logic [NW-1:0] rd_link;
  logic [NW-1:0] head_q;
  logic hit;
  logic success, full;
  logic out_valid;
  logic mix_start;
  chs_pkg::mix_ctl_t mctl;
  logic [63:0] mix_out;

  chs_mix u_mix (.clk(clk), .rst(rst), .start(mix_start), .din(key), .ctl(mctl),
                 .dout(mix_out));

  logic [AW-1:0] rd_addr;
  assign rd_addr = (state == chs_pkg::ST_ALLOC) ? free_head[AW-1:0] : cur[AW-1:0];

  always_ff @(posedge clk) begin
    rd_key <= keys[rd_addr];
    rd_link <= links[rd_addr];
    head_q <= head_ok[bucket] ? heads[bucket] : NULL_NODE;
  end

  always_comb begin
    state_next = state;
    case (state)
      chs_pkg::ST_IDLE: if (req.valid) state_next = chs_pkg::ST_HASH;
      chs_pkg::ST_HASH: if (mctl.done) state_next = chs_pkg::ST_HEAD;
      chs_pkg::ST_HEAD: state_next = chs_pkg::ST_HEAD_WAIT;
      chs_pkg::ST_HEAD_WAIT: state_next = chs_pkg::ST_READ;
      chs_pkg::ST_READ: state_next = (cur >= NULL_NODE || steps >= (NW+1)'(POOL_NODES))
                                     ? chs_pkg::ST_UPDATE : chs_pkg::ST_READ_WAIT;
      chs_pkg::ST_READ_WAIT: state_next = chs_pkg::ST_CMP;
      chs_pkg::ST_CMP: state_next = (rd_key == key) ? chs_pkg::ST_UPDATE
                                                     : chs_pkg::ST_READ;
      chs_pkg::ST_UPDATE: state_next = (action == chs_pkg::ACT_INSERT && !hit &&
                                        free_head < NULL_NODE) ? chs_pkg::ST_ALLOC
                                                               : chs_pkg::ST_OUT;
      chs_pkg::ST_ALLOC: state_next = chs_pkg::ST_ALLOC_WAIT;
      chs_pkg::ST_ALLOC_WAIT: state_next = chs_pkg::ST_OUT;
      chs_pkg::ST_OUT: if (!out_valid) state_next = chs_pkg::ST_IDLE;
      default: state_next = chs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == chs_pkg::ST_IDLE) && !out_valid;
    mix_start = (state == chs_pkg::ST_HASH) && !mctl.busy && !mctl.done;
  end

  // node chosen for an insert of an absent key with an empty free list
  always_comb node = (fresh < NULL_NODE) ? fresh : NULL_NODE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chs_pkg::ST_IDLE;
      head_ok <= '0;
      free_head <= NULL_NODE;
      fresh <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        chs_pkg::ST_IDLE: if (req.valid && req.ready) begin
          action <= req.action;
          key <= req.key;
        end
        chs_pkg::ST_HASH: if (mctl.done) bucket <= mix_out[BW-1:0] & BMASK;
        chs_pkg::ST_HEAD_WAIT: begin
          cur <= head_q;
          prev <= NULL_NODE;
          steps <= '0;
          hit <= 1'b0;
        end
        chs_pkg::ST_CMP: begin
          if (rd_key == key) hit <= 1'b1;
          else begin
            prev <= cur;
            cur <= rd_link;
            steps <= steps + (NW+1)'(1);
          end
        end
        chs_pkg::ST_UPDATE: begin
          if (action == chs_pkg::ACT_FIND) begin
            success <= hit;
            full <= 1'b0;
          end else if (action == chs_pkg::ACT_REMOVE && hit) begin
            // rd_link still holds the link of the hit node
            if (prev < NULL_NODE) links[prev[AW-1:0]] <= rd_link;
            else begin
              heads[bucket] <= rd_link;
              head_ok[bucket] <= 1'b1;
            end
            free_head <= cur;
            if (count != '0) count <= count - NW'(1);
            success <= 1'b1;
            full <= 1'b0;
          end else if (action == chs_pkg::ACT_INSERT && !hit &&
                       free_head >= NULL_NODE) begin
            if (node < NULL_NODE) begin
              keys[node[AW-1:0]] <= key;
              links[node[AW-1:0]] <= head_q;
              heads[bucket] <= node;
              head_ok[bucket] <= 1'b1;
              fresh <= fresh + NW'(1);
              count <= count + NW'(1);
              success <= 1'b1;
              full <= 1'b0;
            end else begin
              success <= 1'b0;
              full <= 1'b1;
            end
          end else begin
            success <= 1'b0;
            full <= 1'b0;
          end
        end
        chs_pkg::ST_ALLOC_WAIT: begin
          keys[free_head[AW-1:0]] <= key;
          links[free_head[AW-1:0]] <= head_q;
          heads[bucket] <= free_head;
          head_ok[bucket] <= 1'b1;
          free_head <= rd_link;
          count <= count + NW'(1);
          success <= 1'b1;
        end
        default: ;
      endcase
      if (state == chs_pkg::ST_UPDATE && action == chs_pkg::ACT_REMOVE && hit)
        links[cur[AW-1:0]] <= free_head;
      if (state == chs_pkg::ST_ALLOC_WAIT || (state == chs_pkg::ST_UPDATE &&
          state_next == chs_pkg::ST_OUT))
        out_valid <= 1'b1;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.success = success;
  assign rsp.pool_full = full;
  assign rsp.element_total = TW'(count);

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == chs_pkg::ST_IDLE && !rsp.valid))
    else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(POOL_NODES))
    else $error("key count above pool size");
  a_full_fail: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.pool_full |-> !rsp.success)
    else $error("pool_full with success");
`endif

endmodule

[verif/tb_chained_hash_set_core.sv]
// tb_chained_hash_set_core: self-checking bench for the chained hash set core
// depends on chs_pkg, chs_if and chained_hash_set_core
`timescale 1ns / 1ps

module tb_chained_hash_set_core;

  localparam int NBKT = 256;
  localparam int NPOOL = 1024;
  localparam int NULLN = NPOOL;
  localparam int NDIR = 20;
  localparam int NRAND = 400;

  typedef struct packed {
    logic success;
    logic pool_full;
    logic [10:0] element_total;
  } set_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chs_req_if req (clk);
  chs_rsp_if rsp (clk);

  chained_hash_set_core #(.BUCKET_COUNT(NBKT), .POOL_NODES(NPOOL)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // shadow copy of the set
  int unsigned heads [NBKT];
  logic [63:0] nkeys [NPOOL];
  int unsigned nlinks [NPOOL];
  int unsigned free_top;
  int unsigned fresh_idx;
  int unsigned held;

  set_rsp_t pending_rsp [$];
  logic [63:0] live_keys [$];
  int errors = 0;
  int src_idle_pct = 10;
  int snk_idle_pct = 88;

  function automatic logic [63:0] fmix(logic [63:0] k);
    k = k ^ (k >> chs_pkg::MIX_SHIFT);
    k = k * chs_pkg::MIX_C1;
    k = k ^ (k >> chs_pkg::MIX_SHIFT);
    k = k * chs_pkg::MIX_C2;
    k = k ^ (k >> chs_pkg::MIX_SHIFT);
    return k;
  endfunction

  function automatic set_rsp_t apply_request(logic [1:0] act, logic [63:0] k);
    set_rsp_t r;
    int unsigned b, prev, cur, hit, node, steps;
    r = '0;
    b = 32'(fmix(k) & 64'(NBKT - 1));
    prev = NULLN;
    hit = NULLN;
    cur = heads[b];
    steps = 0;
    while (steps < NPOOL && cur < NULLN) begin
      if (nkeys[cur] == k) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = nlinks[cur];
      steps++;
    end
    if (act == chs_pkg::ACT_INSERT) begin
      if (hit == NULLN) begin
        node = NULLN;
        if (free_top < NULLN) begin
          node = free_top;
          free_top = nlinks[node];
        end else if (fresh_idx < NULLN) begin
          node = fresh_idx;
          fresh_idx++;
        end
        if (node < NULLN) begin
          nkeys[node] = k;
          nlinks[node] = heads[b];
          heads[b] = node;
          held++;
          r.success = 1'b1;
        end else begin
          r.pool_full = 1'b1;
        end
      end
    end else if (act == chs_pkg::ACT_FIND) begin
      r.success = (hit != NULLN);
    end else if (act == chs_pkg::ACT_REMOVE) begin
      if (hit != NULLN) begin
        if (prev < NULLN) nlinks[prev] = nlinks[hit];
        else heads[b] = nlinks[hit];
        nlinks[hit] = free_top;
        free_top = hit;
        if (held > 0) held--;
        r.success = 1'b1;
      end
    end
    r.element_total = held[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("error: %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  // send one item; optional typed-in expectation is checked against the predictor
  task automatic send_item(logic [1:0] act, logic [63:0] k, bit has_exp, set_rsp_t exp);
    set_rsp_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.key <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = apply_request(act, k);
    if (has_exp && p != exp) report_mismatch("directed row", 64'(p), 64'(exp));
    pending_rsp.push_back(p);
    if (act == chs_pkg::ACT_INSERT && p.success) live_keys.push_back(k);
  endtask

  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    set_rsp_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected item", 64'd0, 64'd0);
      end else begin
        w = pending_rsp.pop_front();
        if (rsp.success !== w.success)
          report_mismatch("success", 64'(rsp.success), 64'(w.success));
        if (rsp.pool_full !== w.pool_full)
          report_mismatch("pool_full", 64'(rsp.pool_full), 64'(w.pool_full));
        if (rsp.element_total !== w.element_total)
          report_mismatch("element_total", 64'(rsp.element_total),
                          64'(w.element_total));
      end
    end
  end

  typedef struct {
    logic [1:0] act;
    logic [63:0] k;
    bit has_exp;
    set_rsp_t exp;
  } row_t;

  row_t dir_rows [NDIR];

  function automatic row_t mk(logic [1:0] a, logic [63:0] k, bit h, logic s, logic f,
                              logic [10:0] t);
    row_t r;
    r.act = a;
    r.k = k;
    r.has_exp = h;
    r.exp = '{success: s, pool_full: f, element_total: t};
    return r;
  endfunction

  function automatic logic [63:0] pick_key();
    if (live_keys.size() > 0 && $urandom_range(99) < 60)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    if ($urandom_range(99) < 50) return {32'h0, 24'h0, 8'($urandom_range(31))};
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [1:0] a;
    int n;
    int r;
    req.valid = 1'b0;
    req.action = chs_pkg::ACT_FIND;
    req.key = '0;
    for (int i = 0; i < NBKT; i++) heads[i] = NULLN;
    for (int i = 0; i < NPOOL; i++) begin
      nkeys[i] = '0;
      nlinks[i] = NULLN;
    end
    free_top = NULLN;
    fresh_idx = 0;
    held = 0;

    dir_rows[0] = mk(chs_pkg::ACT_FIND, 64'h0, 1, 0, 0, 0);
    dir_rows[1] = mk(chs_pkg::ACT_REMOVE, 64'h0, 1, 0, 0, 0);
    dir_rows[2] = mk(chs_pkg::ACT_NOP, 64'hffff_ffff_ffff_ffff, 1, 0, 0, 0);
    dir_rows[3] = mk(chs_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 1, 1, 0, 1);
    dir_rows[4] = mk(chs_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 1, 0, 0, 1);
    dir_rows[5] = mk(chs_pkg::ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 1, 1, 0, 2);
    dir_rows[6] = mk(chs_pkg::ACT_INSERT, 64'h0, 1, 1, 0, 3);
    dir_rows[7] = mk(chs_pkg::ACT_INSERT, 64'hffff_ffff_ffff_ffff, 1, 1, 0, 4);
    dir_rows[8] = mk(chs_pkg::ACT_FIND, 64'h7fff_ffff_ffff_ffff, 1, 1, 0, 4);
    dir_rows[9] = mk(chs_pkg::ACT_FIND, 64'h1, 1, 0, 0, 4);
    dir_rows[10] = mk(chs_pkg::ACT_NOP, 64'h0, 1, 0, 0, 4);
    dir_rows[11] = mk(chs_pkg::ACT_REMOVE, 64'h0, 1, 1, 0, 3);
    dir_rows[12] = mk(chs_pkg::ACT_REMOVE, 64'h0, 1, 0, 0, 3);
    dir_rows[13] = mk(chs_pkg::ACT_INSERT, 64'h5555_5555_5555_5555, 1, 1, 0, 4);
    dir_rows[14] = mk(chs_pkg::ACT_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 0, 0, 0, 0);
    dir_rows[15] = mk(chs_pkg::ACT_REMOVE, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
    dir_rows[16] = mk(chs_pkg::ACT_FIND, 64'haaaa_aaaa_aaaa_aaaa, 0, 0, 0, 0);
    dir_rows[17] = mk(chs_pkg::ACT_REMOVE, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0);
    dir_rows[18] = mk(chs_pkg::ACT_FIND, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
    dir_rows[19] = mk(chs_pkg::ACT_INSERT, 64'h0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++)
      send_item(dir_rows[i].act, dir_rows[i].k, dir_rows[i].has_exp, dir_rows[i].exp);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
      snk_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
      n = (ph == 1) ? NRAND / 6 : NRAND / 3;
      for (int i = 0; i < n; i++) begin
        r = int'($urandom_range(99));
        if (r < 45) a = chs_pkg::ACT_INSERT;
        else if (r < 70) a = chs_pkg::ACT_FIND;
        else if (r < 97) a = chs_pkg::ACT_REMOVE;
        else a = chs_pkg::ACT_NOP;
        send_item(a, pick_key(), 0, '0);
      end
    end

    for (int i = 0; i < 30; i++) send_item(chs_pkg::ACT_REMOVE, pick_key(), 0, '0);
    for (int i = 0; i < 30; i++) send_item(chs_pkg::ACT_INSERT, pick_key(), 0, '0);
    req.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("chained_hash_set_core: match");
    else $display("chained_hash_set_core: mismatch");
    $finish;
  end

  initial begin
    #80ms;
    $display("chained_hash_set_core: mismatch");
    $finish;
  end

endmodule

[files.f]
sv/chs_pkg.sv
sv/chs_if.sv
sv/chs_mix.sv
sv/chained_hash_set_core.sv
verif/tb_chained_hash_set_core.sv
